// ===== sv/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and key codes for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [7:0] KEY_LEFT      = 8'h83;
  localparam logic [7:0] KEY_RIGHT     = 8'h84;

  localparam logic FUNC_EDIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_READ,
    OP_INSERT,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_LEFT,
    OP_RIGHT
  } leb_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_BS_FIN,
    ST_DONE
  } leb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_cap;
    logic sh_rd;
    logic sh_wr;
    logic ins_wr;
    logic bs_fin;
    logic out_load;
  } leb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    leb_op_t op;
    logic    full;
    logic    at_end;
    logic    cur_zero;
    logic    last;
  } leb_status_t;

  function automatic leb_op_t decode_op(input logic func, input logic [7:0] key);
    leb_op_t op;
    if (func == FUNC_READ) begin
      op = OP_READ;
    end else begin
      case (key)
        KEY_BACKSPACE: op = OP_BACKSPACE;
        KEY_NEWLINE:   op = OP_NEWLINE;
        KEY_LEFT:      op = OP_LEFT;
        KEY_RIGHT:     op = OP_RIGHT;
        default:       op = OP_INSERT;
      endcase
    end
    return op;
  endfunction

endpackage

// ===== sv/leb_ram.sv =====
// ----------------------------------------------------------------------------
// leb_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// leb_ctrl
// Sequencer for the line edit buffer: steps each item through decode,
// the tail shift over the line RAM, and the result register.
// ----------------------------------------------------------------------------
module leb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  leb_pkg::leb_status_t stat,
  output leb_pkg::leb_cmd_t    cmd
);
  import leb_pkg::*;

  leb_state_t state, state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.op)
          OP_READ: state_next = ST_RD_WAIT;
          OP_INSERT: begin
            if (stat.full)        state_next = ST_DONE;
            else if (stat.at_end) state_next = ST_INS_WR;
            else                  state_next = ST_SH_RD;
          end
          OP_BACKSPACE: begin
            if (stat.cur_zero)    state_next = ST_DONE;
            else if (stat.at_end) state_next = ST_BS_FIN;
            else                  state_next = ST_SH_RD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_SH_RD:   state_next = ST_SH_WR;
      ST_SH_WR: begin
        if (stat.last) begin
          state_next = (stat.op == OP_INSERT) ? ST_INS_WR : ST_BS_FIN;
        end else begin
          state_next = ST_SH_RD;
        end
      end
      ST_INS_WR: state_next = ST_DONE;
      ST_BS_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == ST_IDLE) && s_tvalid;
    cmd.exec     = (state == ST_EXEC);
    cmd.rd_cap   = (state == ST_RD_WAIT);
    cmd.sh_rd    = (state == ST_SH_RD);
    cmd.sh_wr    = (state == ST_SH_WR);
    cmd.ins_wr   = (state == ST_INS_WR);
    cmd.bs_fin   = (state == ST_BS_FIN);
    cmd.out_load = (state == ST_DONE) && out_free;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result valid raised outside the done step");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result valid dropped before its transfer");
`endif

endmodule

// ===== sv/leb_datapath.sv =====
// ----------------------------------------------------------------------------
// leb_datapath
// Cursor, length, shift pointer, line RAM and result register of the line
// edit buffer.
// ----------------------------------------------------------------------------
module leb_datapath #(
  parameter int LINE_SIZE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_func,
  input  logic [15:0]          s_data,
  output logic [31:0]          m_data,
  input  leb_pkg::leb_cmd_t    cmd,
  output leb_pkg::leb_status_t stat
);
  import leb_pkg::*;

  localparam int AW = $clog2(LINE_SIZE);
  localparam int CW = $clog2(LINE_SIZE + 1);
  localparam logic [CW-1:0] LINE_MAX = CW'(LINE_SIZE);

  logic          func_q;
  logic [7:0]    key_q;
  logic [7:0]    idx_q;
  logic [CW-1:0] cursor;
  logic [CW-1:0] length;
  logic [CW-1:0] ptr;
  logic          status_q;
  logic [7:0]    rdata;

  leb_op_t       op;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] ptr_p1;
  logic [CW+7:0] idx_w;
  logic [CW+7:0] len_w;
  logic          in_range;
  logic [CW+8:0] cur_ext;
  logic [CW+8:0] len_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_q;

  assign op       = decode_op(func_q, key_q);
  assign ptr_m1   = ptr - 1'b1;
  assign ptr_p1   = ptr + 1'b1;
  assign idx_w    = {{CW{1'b0}}, idx_q};
  assign len_w    = {8'd0, length};
  // A position below the length is always below the line size as well.
  assign in_range = idx_w < len_w;
  assign cur_ext  = {9'd0, cursor};
  assign len_ext  = {9'd0, length};

  assign stat.op       = op;
  assign stat.full     = (length == LINE_MAX);
  assign stat.at_end   = (cursor == length);
  assign stat.cur_zero = (cursor == '0);
  assign stat.last     = (op == OP_INSERT) ? (ptr_m1 == cursor) : (ptr_p1 == length);

  // Insert moves the tail upward starting from the top; backspace moves it
  // down starting from the cursor. Each element takes a read and a write.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_w[AW-1:0];
    if (cmd.exec && (op == OP_READ) && in_range) begin
      ram_re = 1'b1;
    end else if (cmd.sh_rd) begin
      ram_re    = 1'b1;
      ram_raddr = (op == OP_INSERT) ? ptr_m1[AW-1:0] : ptr[AW-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor[AW-1:0];
    ram_wdata = key_q;
    if (cmd.sh_wr) begin
      ram_we    = 1'b1;
      ram_waddr = (op == OP_INSERT) ? ptr[AW-1:0] : ptr_m1[AW-1:0];
      ram_wdata = ram_q;
    end else if (cmd.ins_wr) begin
      ram_we = 1'b1;
    end
  end

  leb_ram #(
    .WIDTH (8),
    .DEPTH (LINE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= s_func;
      key_q  <= s_data[7:0];
      idx_q  <= s_data[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      length <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_NEWLINE: cursor <= '0;
        OP_LEFT:    if (!stat.cur_zero) cursor <= cursor - 1'b1;
        OP_RIGHT:   if (!stat.at_end) cursor <= cursor + 1'b1;
        default:    ;
      endcase
    end else if (cmd.ins_wr) begin
      cursor <= cursor + 1'b1;
      length <= length + 1'b1;
    end else if (cmd.bs_fin) begin
      cursor <= cursor - 1'b1;
      length <= length - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ptr      <= (op == OP_INSERT) ? length : cursor;
      status_q <= (op == OP_INSERT) && stat.full;
      rdata    <= 8'd0;
    end else begin
      if (cmd.sh_wr) begin
        ptr <= (op == OP_INSERT) ? ptr_m1 : ptr_p1;
      end
      if (cmd.rd_cap && in_range) begin
        rdata <= ram_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_data <= {5'd0, rdata, status_q, len_ext[8:0], cur_ext[8:0]};
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond line length");

  a_length_in_size: assert property (@(posedge clk) disable iff (rst)
    length <= LINE_MAX)
    else $error("line length beyond line size");

  a_write_in_line: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({{(CW > AW ? CW - AW : 0){1'b0}}, ram_waddr} <= {1'b0, length}))
    else $error("line write beyond the held length");
`endif

endmodule

// ===== sv/line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer
// Terminal line-editing store driven by key bytes, with cursor, length and
// an indexed read of the line.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser = func, s_tdata = key, read_index
//   m_*      out  m_tvalid/m_tready  m_tdata = cursor_pos, line_length,
//                                    status, read_data
//
// Cursor moves, newline, full inserts and backspace at the head of the line
// go from decode straight to the result; a read first waits for the RAM.
// Other inserts and backspaces shift the tail before the result: it moves one
// entry per read/write pair through the single-write, registered-read line RAM.
// Reset clears cursor and length only; the line RAM needs no clearing pass.
// A new item is taken while a result waits; its result is held back until
// the output register is free.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int LINE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] key, [15:8] read_index
  input  logic        s_tuser,  // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // [8:0] cursor_pos, [17:9] line_length,
                                // [18] status, [26:19] read_data, rest zero
);
  import leb_pkg::*;

  leb_cmd_t    cmd;
  leb_status_t stat;

  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  leb_datapath #(
    .LINE_SIZE (LINE_SIZE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .s_func (s_tuser),
    .s_data (s_tdata),
    .m_data (m_tdata),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== dv/tb_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_line_edit_buffer
// Self-checking testbench for the line edit buffer. Key and read transfers
// are fed from a queue by a clocked driver, and a clocked monitor checks
// every result transfer against a line/cursor model kept in the testbench.
// Both sides idle at random, and the receiver holds off for long stretches
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_line_edit_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import leb_pkg::*;

  localparam int LINE_SIZE   = 256;
  localparam int ITEM_TARGET = 850;
  localparam int DRAIN_WAIT  = 2 * LINE_SIZE + 100;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic       func;
    logic [7:0] key;
    logic [7:0] read_index;
  } key_item_t;

  typedef struct packed {
    logic [8:0] cursor_pos;
    logic [8:0] line_length;
    logic       status;
    logic [7:0] read_data;
  } edit_result_t;

  typedef enum int {
    SESS_TYPING,
    SESS_FILL,
    SESS_ERASE,
    SESS_READS
  } session_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  key_item_t    pending_keys[$];
  edit_result_t expected_results[$];

  // Model of the line: the queue holds the characters, its size is the length.
  logic [7:0]  line_chars[$];
  int unsigned line_cursor = 0;

  int          error_count    = 0;
  int          accepted_count = 0;
  int          cycle_count    = 0;
  int          hold_left      = 0;
  logic [1:0]  hold_fired     = '0;

  key_item_t   tx_item;
  int          tx_wait  = 0;
  int          tx_calm  = 0;
  logic        tx_next_valid;
  int          rx_wait  = 0;
  int          rx_calm  = 0;

  line_edit_buffer #(
    .LINE_SIZE(LINE_SIZE)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #6 clk = ~clk;

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic edit_result_t apply_key_item(input key_item_t it);
    edit_result_t res;
    res = '0;
    if (it.func == FUNC_READ) begin
      if (it.read_index < line_chars.size()) res.read_data = line_chars[it.read_index];
    end else begin
      case (it.key)
        KEY_BACKSPACE: begin
          if (line_cursor > 0) begin
            line_chars.delete(line_cursor - 1);
            line_cursor--;
          end
        end
        KEY_NEWLINE: begin
          line_cursor = 0;
        end
        KEY_LEFT: begin
          if (line_cursor > 0) line_cursor--;
        end
        KEY_RIGHT: begin
          if (line_cursor < line_chars.size()) line_cursor++;
        end
        default: begin
          if (line_chars.size() >= LINE_SIZE) begin
            res.status = 1'b1;
          end else begin
            line_chars.insert(line_cursor, it.key);
            line_cursor++;
          end
        end
      endcase
    end
    res.cursor_pos  = line_cursor[8:0];
    res.line_length = 9'(line_chars.size());
    return res;
  endfunction

  // Wait drawn per transfer; now and then a calm stretch with no idling at all.
  function automatic int draw_idle(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic push_edit(input logic [7:0] key);
    key_item_t it;
    it.func       = FUNC_EDIT;
    it.key        = key;
    it.read_index = 8'($urandom_range(0, 255));
    pending_keys.push_back(it);
  endtask

  task automatic push_read(input logic [7:0] idx);
    key_item_t it;
    it.func       = FUNC_READ;
    it.key        = 8'($urandom_range(0, 255));
    it.read_index = idx;
    pending_keys.push_back(it);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (ch == KEY_BACKSPACE || ch == KEY_NEWLINE || ch == KEY_LEFT ||
               ch == KEY_RIGHT);
    return ch;
  endfunction

  task automatic add_session(input session_kind_t kind, input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      case (kind)
        SESS_FILL: begin
          if (pick < 94) push_edit(random_char());
          else if (pick < 97) push_edit(KEY_LEFT);
          else push_edit(KEY_RIGHT);
        end
        SESS_ERASE: begin
          if (pick < 85) push_edit(KEY_BACKSPACE);
          else push_edit(KEY_RIGHT);
        end
        SESS_READS: begin
          push_read(8'($urandom_range(0, 255)));
        end
        default: begin
          if (pick < 50) push_edit(random_char());
          else if (pick < 60) push_edit(KEY_BACKSPACE);
          else if (pick < 68) push_edit(KEY_LEFT);
          else if (pick < 76) push_edit(KEY_RIGHT);
          else if (pick < 80) push_edit(KEY_NEWLINE);
          else push_read(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic check_result(input logic [31:0] word);
    edit_result_t got;
    edit_result_t want;
    got.cursor_pos  = word[8:0];
    got.line_length = word[17:9];
    got.status      = word[18];
    got.read_data   = word[26:19];
    if (expected_results.size() == 0) begin
      report_error($sformatf("result 0x%08h with nothing outstanding", word));
    end else begin
      want = expected_results.pop_front();
      if (got.cursor_pos !== want.cursor_pos)
        report_error($sformatf("cursor_pos %0d, expected %0d", got.cursor_pos,
                               want.cursor_pos));
      if (got.line_length !== want.line_length)
        report_error($sformatf("line_length %0d, expected %0d", got.line_length,
                               want.line_length));
      if (got.status !== want.status)
        report_error($sformatf("status %0b, expected %0b", got.status, want.status));
      if (got.read_data !== want.read_data)
        report_error($sformatf("read_data 0x%02h, expected 0x%02h", got.read_data,
                               want.read_data));
    end
  endtask

  // Driver: the model is advanced when the block takes a transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      tx_next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_key_item(tx_item));
        accepted_count <= accepted_count + 1;
        tx_next_valid = 1'b0;
        tx_wait = draw_idle(tx_calm);
      end
      if (!tx_next_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_keys.size() > 0) begin
          tx_item = pending_keys.pop_front();
          s_tdata <= {tx_item.read_index, tx_item.key};
          s_tuser <= tx_item.func;
          tx_next_valid = 1'b1;
        end
      end
      s_tvalid <= tx_next_valid;
    end
  end

  // Long receiver hold-offs, fired twice during the run.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_fired[0] && accepted_count >= 150) begin
      hold_fired[0] <= 1'b1;
      hold_left     <= HOLD_CYCLES;
    end else if (!hold_fired[1] && accepted_count >= 600) begin
      hold_fired[1] <= 1'b1;
      hold_left     <= HOLD_CYCLES;
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        rx_wait = draw_idle(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // Directed part: empty line corners, every key kind, moves at both ends,
    // mid-line insert and delete, and reads that carry a stray key byte.
    push_read(8'h00);
    push_read(8'hFF);
    push_edit(KEY_BACKSPACE);
    push_edit(KEY_LEFT);
    push_edit(KEY_RIGHT);
    push_edit(KEY_NEWLINE);
    push_edit(8'h00);
    push_edit(8'hFF);
    push_edit(8'h85);
    push_edit(8'h86);
    push_edit(8'h41);
    push_edit(KEY_RIGHT);
    push_edit(KEY_LEFT);
    push_edit(KEY_LEFT);
    push_edit(8'h55);
    push_edit(KEY_BACKSPACE);
    push_edit(KEY_BACKSPACE);
    push_edit(KEY_NEWLINE);
    push_edit(KEY_BACKSPACE);
    push_edit(KEY_LEFT);
    push_read(8'h00);
    push_read(8'h03);
    push_read(8'h05);
    push_read(8'hC8);

    // Random part: build the line until it overflows, read it all over,
    // erase much of it, then free editing.
    add_session(SESS_TYPING, 60);
    add_session(SESS_FILL, 300);
    add_session(SESS_READS, 40);
    add_session(SESS_ERASE, 120);
    while (pending_keys.size() < ITEM_TARGET)
      add_session(SESS_TYPING, $urandom_range(10, 60));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_keys.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/leb_pkg.sv
sv/leb_ram.sv
sv/leb_ctrl.sv
sv/leb_datapath.sv
sv/line_edit_buffer.sv
dv/tb_line_edit_buffer.sv
